>>> hdl/lmrs_pkg.sv
// Package for the LED matrix row command sequencer: payload structs, opcodes,
// decoded command kinds, driver register addresses and sizing constants. No dependencies.
package lmrs_pkg;

  localparam int unsigned Rows          = 8;
  localparam int unsigned RowW          = $clog2(Rows);
  localparam int unsigned FrameW        = 8 * Rows;
  localparam int unsigned CmdQueueDepth = 2;
  localparam int unsigned StepW         = 4;

  localparam logic [3:0] AddrRow0      = 4'd1;
  localparam logic [3:0] AddrIntensity = 4'd10;
  localparam logic [3:0] AddrScanLimit = 4'd11;
  localparam logic [3:0] AddrShutdown  = 4'd12;
  localparam logic [3:0] AddrTest      = 4'd15;

  localparam logic [7:0] ByteZero      = 8'h00;
  localparam logic [7:0] ByteOne       = 8'h01;
  localparam logic [7:0] ByteFull      = 8'hFF;
  localparam logic [7:0] MaxLevel      = 8'h0F;
  localparam logic [7:0] ScanLimitAll  = 8'd7;
  localparam logic [7:0] PixelMaskTop  = 8'h80;

  // Init sequence steps before the row writes begin.
  localparam logic [StepW-1:0] StepShutdownOn = 4'd0;
  localparam logic [StepW-1:0] StepShutdownOff = 4'd1;
  localparam logic [StepW-1:0] StepScanLimit = 4'd2;

  typedef enum logic [3:0] {
    OP_INIT       = 4'd0,
    OP_RESET      = 4'd1,
    OP_TEST_ON    = 4'd2,
    OP_TEST_OFF   = 4'd3,
    OP_CLEAR      = 4'd4,
    OP_FILL       = 4'd5,
    OP_BRIGHTNESS = 4'd6,
    OP_SET_PIXEL  = 4'd7,
    OP_CLR_PIXEL  = 4'd8,
    OP_FRAME      = 4'd9
  } opcode_e;

  typedef enum logic [2:0] {
    K_INIT,
    K_RESET,
    K_TEST,
    K_ROWS,
    K_INTENSITY,
    K_PIXEL
  } cmd_kind_e;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_e;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [7:0]  row;
    logic [7:0]  column;
    logic [7:0]  level;
    logic [63:0] frame;
  } cmd_in_t;

  typedef struct packed {
    logic [3:0] reg_address;
    logic [7:0] reg_value;
    logic       last;
  } wr_out_t;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [RowW-1:0]   row;
    logic [7:0]        mask;
    logic [7:0]        value;
    logic [FrameW-1:0] frame;
  } cmd_dec_t;

endpackage

>>> hdl/lmrs_front.sv
// Front end of the LED matrix row command sequencer: classifies incoming commands.
// Depends on lmrs_pkg. Drops commands that cause no register write.
module lmrs_front (
  input  lmrs_pkg::cmd_in_t  cmd_i,
  output logic               keep_o,
  output lmrs_pkg::cmd_dec_t dec_o
);

  logic pixel_ok;

  assign pixel_ok = (cmd_i.row < 8'(lmrs_pkg::Rows)) && (cmd_i.column < 8'd8);

  always_comb begin
    keep_o      = 1'b1;
    dec_o.kind  = lmrs_pkg::K_RESET;
    dec_o.row   = cmd_i.row[lmrs_pkg::RowW-1:0];
    dec_o.mask  = lmrs_pkg::PixelMaskTop >> cmd_i.column[2:0];
    dec_o.value = lmrs_pkg::ByteZero;
    dec_o.frame = cmd_i.frame[lmrs_pkg::FrameW-1:0];
    case (cmd_i.opcode)
      lmrs_pkg::OP_INIT: begin
        dec_o.kind = lmrs_pkg::K_INIT;
      end
      lmrs_pkg::OP_RESET: begin
        dec_o.kind = lmrs_pkg::K_RESET;
      end
      lmrs_pkg::OP_TEST_ON: begin
        dec_o.kind  = lmrs_pkg::K_TEST;
        dec_o.value = lmrs_pkg::ByteOne;
      end
      lmrs_pkg::OP_TEST_OFF: begin
        dec_o.kind  = lmrs_pkg::K_TEST;
        dec_o.value = lmrs_pkg::ByteZero;
      end
      lmrs_pkg::OP_CLEAR: begin
        dec_o.kind  = lmrs_pkg::K_ROWS;
        dec_o.frame = {lmrs_pkg::Rows{lmrs_pkg::ByteZero}};
      end
      lmrs_pkg::OP_FILL: begin
        dec_o.kind  = lmrs_pkg::K_ROWS;
        dec_o.frame = {lmrs_pkg::Rows{lmrs_pkg::ByteFull}};
      end
      lmrs_pkg::OP_BRIGHTNESS: begin
        dec_o.kind  = lmrs_pkg::K_INTENSITY;
        dec_o.value = (cmd_i.level > lmrs_pkg::MaxLevel) ? lmrs_pkg::MaxLevel : cmd_i.level;
      end
      lmrs_pkg::OP_SET_PIXEL: begin
        dec_o.kind  = lmrs_pkg::K_PIXEL;
        dec_o.value = lmrs_pkg::ByteOne;
        keep_o      = pixel_ok;
      end
      lmrs_pkg::OP_CLR_PIXEL: begin
        dec_o.kind  = lmrs_pkg::K_PIXEL;
        dec_o.value = lmrs_pkg::ByteZero;
        keep_o      = pixel_ok;
      end
      lmrs_pkg::OP_FRAME: begin
        dec_o.kind = lmrs_pkg::K_ROWS;
      end
      default: begin
        keep_o = 1'b0;
      end
    endcase
  end

endmodule

>>> hdl/lmrs_cmd_fifo.sv
// Short queue of decoded commands between the front end and the back end.
// Depends on lmrs_pkg for the decoded command type.
module lmrs_cmd_fifo #(
  parameter int unsigned Depth = lmrs_pkg::CmdQueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  lmrs_pkg::cmd_dec_t wr_data_i,
  output logic               full_o,
  input  logic               rd_en_i,
  output lmrs_pkg::cmd_dec_t rd_data_o,
  output logic               empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  lmrs_pkg::cmd_dec_t entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_wr, do_rd;

  assign full_o    = (count_q == CntW'(Depth));
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      entry_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

>>> hdl/lmrs_back.sv
// Back end of the LED matrix row command sequencer: holds the shadow rows and emits
// one register write per cycle while its output register is free. Depends on lmrs_pkg.
module lmrs_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  lmrs_pkg::cmd_dec_t q_data_i,
  output logic               q_pop_o,
  output lmrs_pkg::wr_out_t  wr_o,
  output logic               empty_o,
  input  logic               pop_i
);

  lmrs_pkg::back_state_e state_q, state_d;
  lmrs_pkg::cmd_dec_t    cmd_q, cmd_d;
  logic [lmrs_pkg::StepW-1:0] step_q, step_d;
  logic [lmrs_pkg::RowW-1:0]  row_q, row_d;
  logic [7:0]                 shadow_q [lmrs_pkg::Rows];
  logic [7:0]                 cur_row;
  logic [7:0]                 new_row;
  logic                       load;
  logic                       emit;
  logic                       out_free;
  logic                       out_valid_q;
  lmrs_pkg::wr_out_t          out_q, wr_next;

  assign cur_row  = shadow_q[row_q];
  assign new_row  = (cmd_q.value == lmrs_pkg::ByteOne) ? (cur_row | cmd_q.mask)
                                                       : (cur_row & ~cmd_q.mask);
  assign out_free = !out_valid_q || pop_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lmrs_pkg::BK_IDLE;
      step_q  <= '0;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      row_q   <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    step_d  = step_q;
    row_d   = row_q;
    q_pop_o = 1'b0;
    load    = 1'b0;
    emit    = 1'b0;
    wr_next.reg_address = lmrs_pkg::AddrRow0 + 4'(row_q);
    wr_next.reg_value   = cur_row;
    wr_next.last        = (row_q == lmrs_pkg::RowW'(lmrs_pkg::Rows - 1));
    case (state_q)
      lmrs_pkg::BK_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          load    = 1'b1;
          cmd_d   = q_data_i;
          step_d  = '0;
          row_d   = (q_data_i.kind == lmrs_pkg::K_PIXEL) ? q_data_i.row : '0;
          state_d = lmrs_pkg::BK_RUN;
        end
      end
      lmrs_pkg::BK_RUN: begin
        case (cmd_q.kind)
          lmrs_pkg::K_INIT: begin
            if (step_q == lmrs_pkg::StepShutdownOn) begin
              wr_next.reg_address = lmrs_pkg::AddrShutdown;
              wr_next.reg_value   = lmrs_pkg::ByteZero;
              wr_next.last        = 1'b0;
            end else if (step_q == lmrs_pkg::StepShutdownOff) begin
              wr_next.reg_address = lmrs_pkg::AddrShutdown;
              wr_next.reg_value   = lmrs_pkg::ByteOne;
              wr_next.last        = 1'b0;
            end else if (step_q == lmrs_pkg::StepScanLimit) begin
              wr_next.reg_address = lmrs_pkg::AddrScanLimit;
              wr_next.reg_value   = lmrs_pkg::ScanLimitAll;
              wr_next.last        = 1'b0;
            end
          end
          lmrs_pkg::K_RESET: begin
            wr_next.reg_address = lmrs_pkg::AddrShutdown;
            wr_next.reg_value   = (step_q == lmrs_pkg::StepShutdownOn) ? lmrs_pkg::ByteZero
                                                                       : lmrs_pkg::ByteOne;
            wr_next.last        = (step_q == lmrs_pkg::StepShutdownOff);
          end
          lmrs_pkg::K_TEST: begin
            wr_next.reg_address = lmrs_pkg::AddrTest;
            wr_next.reg_value   = cmd_q.value;
            wr_next.last        = 1'b1;
          end
          lmrs_pkg::K_INTENSITY: begin
            wr_next.reg_address = lmrs_pkg::AddrIntensity;
            wr_next.reg_value   = cmd_q.value;
            wr_next.last        = 1'b1;
          end
          lmrs_pkg::K_PIXEL: begin
            wr_next.reg_value = new_row;
            wr_next.last      = 1'b1;
          end
          default: begin
          end
        endcase
        if (out_free) begin
          emit   = 1'b1;
          step_d = step_q + 1'b1;
          if (cmd_q.kind == lmrs_pkg::K_ROWS ||
              (cmd_q.kind == lmrs_pkg::K_INIT && step_q > lmrs_pkg::StepScanLimit)) begin
            row_d = row_q + 1'b1;
          end
          if (wr_next.last) begin
            state_d = lmrs_pkg::BK_IDLE;
          end
        end
      end
      default: begin
        state_d = lmrs_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < lmrs_pkg::Rows; r++) begin
        shadow_q[r] <= lmrs_pkg::ByteZero;
      end
    end else if (load && q_data_i.kind == lmrs_pkg::K_INIT) begin
      for (int r = 0; r < lmrs_pkg::Rows; r++) begin
        shadow_q[r] <= lmrs_pkg::ByteZero;
      end
    end else if (load && q_data_i.kind == lmrs_pkg::K_ROWS) begin
      for (int r = 0; r < lmrs_pkg::Rows; r++) begin
        shadow_q[r] <= q_data_i.frame[8*r +: 8];
      end
    end else if (emit && cmd_q.kind == lmrs_pkg::K_PIXEL) begin
      shadow_q[row_q] <= new_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= wr_next;
    end
  end

  assign wr_o    = out_q;
  assign empty_o = !out_valid_q;

endmodule

>>> hdl/led_matrix_row_command_sequencer_core.sv
// Top level of the LED matrix row command sequencer.
// Depends on lmrs_pkg, lmrs_front, lmrs_cmd_fifo and lmrs_back.
//
// Each command pushed in becomes a run of display-driver register writes, popped
// one per transaction, with last set on the final write of the command. The back
// end takes a command from the internal queue while idle, then emits its writes,
// holding while the result side stalls. Init writes shutdown on, off, scan limit,
// then all rows as clear, fill and frame do; reset writes shutdown on and off; the
// rest one register. Pixels out of range and unused opcodes are dropped on entry
// and emit nothing. The queue takes further commands while the back end works.
module led_matrix_row_command_sequencer_core #(
  parameter int unsigned CmdQueueDepth = lmrs_pkg::CmdQueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lmrs_pkg::cmd_in_t cmd_i,
  input  logic              push,
  output logic              full,
  output lmrs_pkg::wr_out_t wr_o,
  output logic              empty,
  input  logic              pop
);

  lmrs_pkg::cmd_dec_t dec;
  lmrs_pkg::cmd_dec_t q_data;
  logic               keep;
  logic               q_empty;
  logic               q_pop;

  lmrs_front u_front (
    .cmd_i  (cmd_i),
    .keep_o (keep),
    .dec_o  (dec)
  );

  lmrs_cmd_fifo #(
    .Depth (CmdQueueDepth)
  ) u_cmd_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (push && keep),
    .wr_data_i (dec),
    .full_o    (full),
    .rd_en_i   (q_pop),
    .rd_data_o (q_data),
    .empty_o   (q_empty)
  );

  lmrs_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (q_data),
    .q_pop_o   (q_pop),
    .wr_o      (wr_o),
    .empty_o   (empty),
    .pop_i     (pop)
  );

endmodule

>>> test/tb_led_matrix_row_command_sequencer_core.sv
// Self-checking testbench for led_matrix_row_command_sequencer_core: commands are pushed under
// varied idling and back-pressure, and every register write is checked against a local predictor.
// Depends on lmrs_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_led_matrix_row_command_sequencer_core;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned LongHold = 300;
  localparam int unsigned TailCycles = 30;
  localparam logic [3:0] OpUnusedLow = 4'd10;
  localparam logic [3:0] OpUnusedHigh = 4'd15;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  lmrs_pkg::cmd_in_t cmd_i = '0;
  logic push = 1'b0;
  logic full;
  lmrs_pkg::wr_out_t wr_o;
  logic empty;
  logic pop = 1'b0;

  lmrs_pkg::cmd_in_t pending_cmds[$];
  lmrs_pkg::wr_out_t expected_writes[$];
  logic [7:0] shadow_rows [lmrs_pkg::Rows] = '{default: 8'h00};
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit cmd_taken = 1'b0;
  bit hold_go = 1'b0;
  bit rx_hold = 1'b0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  led_matrix_row_command_sequencer_core dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_i),
    .push  (push),
    .full  (full),
    .wr_o  (wr_o),
    .empty (empty),
    .pop   (pop)
  );

  always #5 clk_i = ~clk_i;

  function automatic lmrs_pkg::wr_out_t reg_write(logic [3:0] addr, logic [7:0] value);
    lmrs_pkg::wr_out_t w;
    w.reg_address = addr;
    w.reg_value = value;
    w.last = 1'b0;
    return w;
  endfunction

  function automatic void predict_writes(lmrs_pkg::cmd_in_t c);
    lmrs_pkg::wr_out_t writes[$];
    lmrs_pkg::wr_out_t w;
    logic [7:0] mask;
    logic [7:0] level;
    bit rows_out;
    rows_out = 1'b0;
    mask = lmrs_pkg::PixelMaskTop >> c.column[2:0];
    level = (c.level > lmrs_pkg::MaxLevel) ? lmrs_pkg::MaxLevel : c.level;
    case (lmrs_pkg::opcode_e'(c.opcode))
      lmrs_pkg::OP_INIT: begin
        writes.push_back(reg_write(lmrs_pkg::AddrShutdown, lmrs_pkg::ByteZero));
        writes.push_back(reg_write(lmrs_pkg::AddrShutdown, lmrs_pkg::ByteOne));
        writes.push_back(reg_write(lmrs_pkg::AddrScanLimit, lmrs_pkg::ScanLimitAll));
        foreach (shadow_rows[r]) shadow_rows[r] = lmrs_pkg::ByteZero;
        rows_out = 1'b1;
      end
      lmrs_pkg::OP_RESET: begin
        writes.push_back(reg_write(lmrs_pkg::AddrShutdown, lmrs_pkg::ByteZero));
        writes.push_back(reg_write(lmrs_pkg::AddrShutdown, lmrs_pkg::ByteOne));
      end
      lmrs_pkg::OP_TEST_ON: writes.push_back(reg_write(lmrs_pkg::AddrTest, lmrs_pkg::ByteOne));
      lmrs_pkg::OP_TEST_OFF: writes.push_back(reg_write(lmrs_pkg::AddrTest, lmrs_pkg::ByteZero));
      lmrs_pkg::OP_CLEAR: begin
        foreach (shadow_rows[r]) shadow_rows[r] = lmrs_pkg::ByteZero;
        rows_out = 1'b1;
      end
      lmrs_pkg::OP_FILL: begin
        foreach (shadow_rows[r]) shadow_rows[r] = lmrs_pkg::ByteFull;
        rows_out = 1'b1;
      end
      lmrs_pkg::OP_BRIGHTNESS: begin
        writes.push_back(reg_write(lmrs_pkg::AddrIntensity, level));
      end
      lmrs_pkg::OP_SET_PIXEL, lmrs_pkg::OP_CLR_PIXEL: begin
        if (c.row < lmrs_pkg::Rows && c.column < 8) begin
          if (c.opcode == lmrs_pkg::OP_SET_PIXEL) begin
            shadow_rows[c.row[2:0]] = shadow_rows[c.row[2:0]] | mask;
          end else begin
            shadow_rows[c.row[2:0]] = shadow_rows[c.row[2:0]] & ~mask;
          end
          writes.push_back(reg_write(lmrs_pkg::AddrRow0 + c.row[3:0],
                                     shadow_rows[c.row[2:0]]));
        end
      end
      lmrs_pkg::OP_FRAME: begin
        foreach (shadow_rows[r]) shadow_rows[r] = c.frame[8*r +: 8];
        rows_out = 1'b1;
      end
      default: ;
    endcase
    if (rows_out) begin
      foreach (shadow_rows[r]) begin
        writes.push_back(reg_write(lmrs_pkg::AddrRow0 + 4'(r), shadow_rows[r]));
      end
    end
    if (writes.size() > 0) begin
      w = writes.pop_back();
      w.last = 1'b1;
      writes.push_back(w);
    end
    foreach (writes[i]) expected_writes.push_back(writes[i]);
  endfunction

  function automatic lmrs_pkg::cmd_in_t make_cmd(logic [3:0] op, logic [7:0] row,
                                                 logic [7:0] column, logic [7:0] level,
                                                 logic [63:0] frame);
    lmrs_pkg::cmd_in_t c;
    c.opcode = op;
    c.row = row;
    c.column = column;
    c.level = level;
    c.frame = frame;
    return c;
  endfunction

  function automatic lmrs_pkg::cmd_in_t random_cmd();
    lmrs_pkg::cmd_in_t c;
    int unsigned pick;
    c = make_cmd(4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), {$urandom, $urandom});
    pick = $urandom_range(99);
    if (pick < 4) begin
      c.opcode = 4'($urandom_range(OpUnusedHigh, OpUnusedLow));
    end else if (pick < 44) begin
      c.opcode = $urandom_range(1) ? lmrs_pkg::OP_SET_PIXEL : lmrs_pkg::OP_CLR_PIXEL;
    end else begin
      c.opcode = 4'($urandom_range(lmrs_pkg::OP_FRAME, lmrs_pkg::OP_INIT));
    end
    if ((c.opcode == lmrs_pkg::OP_SET_PIXEL || c.opcode == lmrs_pkg::OP_CLR_PIXEL) &&
        $urandom_range(9) < 8) begin
      c.row = 8'($urandom_range(lmrs_pkg::Rows - 1));
      c.column = 8'($urandom_range(7));
    end
    if ($urandom_range(1)) c.level = 8'($urandom_range(20));
    return c;
  endfunction

  task automatic load_random(int unsigned count);
    repeat (count) pending_cmds.push_back(random_cmd());
  endtask

  task automatic drain();
    while (pending_cmds.size() > 0 || push || expected_writes.size() > 0) @(posedge clk_i);
  endtask

  task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct, int unsigned count);
    sender_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    load_random(count);
    drain();
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && (!push || cmd_taken)) begin
      if (pending_cmds.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        cmd_i <= pending_cmds.pop_front();
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
    pop <= !rx_hold && $urandom_range(99) >= recv_stall_pct;
  end

  always @(posedge clk_i) begin : check_writes
    lmrs_pkg::wr_out_t want_wr;
    cmd_taken <= push && !full;
    if (rst_ni && push && !full) predict_writes(cmd_i);
    if (rst_ni && pop && !empty) begin
      if (expected_writes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected write, expected none, got addr %0d value %02h last %0b",
                 $time, wr_o.reg_address, wr_o.reg_value, wr_o.last);
      end else begin
        want_wr = expected_writes.pop_front();
        if (wr_o.reg_address !== want_wr.reg_address || wr_o.reg_value !== want_wr.reg_value ||
            wr_o.last !== want_wr.last) begin
          mismatches++;
          $display("%0t: expected addr %0d value %02h last %0b, got addr %0d value %02h last %0b",
                   $time, want_wr.reg_address, want_wr.reg_value, want_wr.last,
                   wr_o.reg_address, wr_o.reg_value, wr_o.last);
        end
      end
    end
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // The long receiver hold is timed here so that the sender keeps offering transactions.
  initial begin
    @(posedge hold_go);
    rx_hold <= 1'b1;
    repeat (LongHold) @(negedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin
    pending_cmds.push_back(make_cmd(lmrs_pkg::OP_INIT, 8'hFF, 8'hFF, 8'hFF, '1));
    pending_cmds.push_back(make_cmd(lmrs_pkg::OP_SET_PIXEL, 8'd0, 8'd0, 8'd0, '0));
    pending_cmds.push_back(make_cmd(lmrs_pkg::OP_SET_PIXEL, 8'd7, 8'd7, 8'd0, '0));
    pending_cmds.push_back(make_cmd(lmrs_pkg::OP_SET_PIXEL, 8'd3, 8'd0, 8'd0, '0));
    pending_cmds.push_back(make_cmd(lmrs_pkg::OP_SET_PIXEL, 8'd0, 8'd7, 8'd0, '0));
    pending_cmds.push_back(make_cmd(lmrs_pkg::OP_CLR_PIXEL, 8'd0, 8'd0, 8'd0, '0));
    pending_cmds.push_back(make_cmd(lmrs_pkg::OP_CLR_PIXEL, 8'd7, 8'd7, 8'd0, '0));
    pending_cmds.push_back(make_cmd(lmrs_pkg::OP_SET_PIXEL, 8'd8, 8'd0, 8'd0, '0));
    pending_cmds.push_back(make_cmd(lmrs_pkg::OP_SET_PIXEL, 8'd0, 8'd8, 8'd0, '0));
    pending_cmds.push_back(make_cmd(lmrs_pkg::OP_SET_PIXEL, 8'hFF, 8'hFF, 8'hFF, '1));
    pending_cmds.push_back(make_cmd(lmrs_pkg::OP_CLR_PIXEL, 8'd8, 8'd3, 8'd0, '0));
    pending_cmds.push_back(make_cmd(lmrs_pkg::OP_FILL, 8'd0, 8'd0, 8'd0, '0));
    pending_cmds.push_back(make_cmd(lmrs_pkg::OP_CLR_PIXEL, 8'd4, 8'd2, 8'd0, '0));
    pending_cmds.push_back(make_cmd(lmrs_pkg::OP_CLEAR, 8'd0, 8'd0, 8'd0, '0));
    pending_cmds.push_back(make_cmd(lmrs_pkg::OP_BRIGHTNESS, 8'd0, 8'd0, 8'd0, '0));
    pending_cmds.push_back(make_cmd(lmrs_pkg::OP_BRIGHTNESS, 8'd0, 8'd0, 8'd15, '0));
    pending_cmds.push_back(make_cmd(lmrs_pkg::OP_BRIGHTNESS, 8'd0, 8'd0, 8'd16, '0));
    pending_cmds.push_back(make_cmd(lmrs_pkg::OP_BRIGHTNESS, 8'd0, 8'd0, 8'hFF, '0));
    pending_cmds.push_back(make_cmd(lmrs_pkg::OP_FRAME, 8'd0, 8'd0, 8'd0,
                                    64'h0123456789ABCDEF));
    pending_cmds.push_back(make_cmd(lmrs_pkg::OP_FRAME, 8'd0, 8'd0, 8'd0, '1));
    pending_cmds.push_back(make_cmd(lmrs_pkg::OP_TEST_ON, 8'd0, 8'd0, 8'd0, '0));
    pending_cmds.push_back(make_cmd(lmrs_pkg::OP_TEST_OFF, 8'd0, 8'd0, 8'd0, '0));
    pending_cmds.push_back(make_cmd(lmrs_pkg::OP_RESET, 8'd0, 8'd0, 8'd0, '0));
    pending_cmds.push_back(make_cmd(OpUnusedLow, 8'hFF, 8'hFF, 8'hFF, '1));
    pending_cmds.push_back(make_cmd(OpUnusedHigh, 8'd0, 8'd0, 8'd0, '0));

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    drain();

    hold_go = 1'b1;
    run_phase(0, 0, 25);
    run_phase(0, 0, 45);
    run_phase(88, 0, 40);
    run_phase(0, 88, 40);
    run_phase(33, 33, 45);

    recv_stall_pct = 0;
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
